>>> rtl/core/shbc_pkg.sv
// Package for the horizontal band segment clipper.
// Holds the segment and divider cell types and the register index codes.
package shbc_pkg;

  localparam int CoordW = 32;
  localparam int MagW   = CoordW + 1;       // magnitude of a 33-bit difference
  localparam int ProdW  = 2 * MagW;         // product of two magnitudes
  localparam int RemW   = MagW + 1;         // remainder after one shift
  localparam int DivSteps = MagW;           // quotient bits, quotient < 2^33
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegClipEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] RegYLower     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegYUpper     = 2'd2;

  // first member sits in the highest bits, so start_x lands lowest
  typedef struct packed {
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_x;
  } shbc_seg_t;

  typedef struct packed {
    logic                valid;
    logic                rep_start;
    logic                rep_end;
    logic                neg;
    shbc_seg_t           seg;
    logic [CoordW-1:0]   c;
    logic [MagW-1:0]     den;
    logic [RemW-1:0]     rem;
    logic [MagW-1:0]     low;
    logic [MagW-1:0]     quo;
  } shbc_cell_t;

endpackage

>>> rtl/core/shbc_div_cell.sv
// One restoring-division step of the clipper's divider chain.
// Depends on shbc_pkg for the cell payload type.
module shbc_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  shbc_pkg::shbc_cell_t cell_in,
  output shbc_pkg::shbc_cell_t cell_out
);
  import shbc_pkg::*;

  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] diff;
  logic            fits;
  shbc_cell_t      cell_next;

  always_comb begin
    rem_sh = {cell_in.rem[MagW-1:0], cell_in.low[MagW-1]};
    diff   = rem_sh - {1'b0, cell_in.den};
    fits   = rem_sh >= {1'b0, cell_in.den};
    cell_next     = cell_in;
    cell_next.rem = fits ? diff : rem_sh;
    cell_next.low = {cell_in.low[MagW-2:0], 1'b0};
    cell_next.quo = {cell_in.quo[MagW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

>>> rtl/core/shbc_stage.sv
// One clip stage: crossing test and product, a chain of divider cells, then
// the endpoint update. Depends on shbc_pkg and shbc_div_cell.
module shbc_stage #(
  parameter bit KEEP_BELOW = 1'b1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        clip_enable,
  input  logic [shbc_pkg::CoordW-1:0] bound,
  input  logic                        in_valid,
  input  shbc_pkg::shbc_seg_t         in_seg,
  output logic                        out_valid,
  output shbc_pkg::shbc_seg_t         out_seg
);
  import shbc_pkg::*;

  logic signed [CoordW-1:0] c_s;
  logic out_a, out_b, in_a, in_b;
  logic signed [MagW-1:0] dn, dx, dy;
  logic [MagW-1:0] mdn, mdx, mdy;
  logic [ProdW-1:0] prod;
  shbc_cell_t head_next;
  shbc_cell_t chain [DivSteps+1];

  always_comb begin
    c_s   = signed'(bound);
    out_a = KEEP_BELOW ? (in_seg.start_y > c_s) : (in_seg.start_y < c_s);
    out_b = KEEP_BELOW ? (in_seg.end_y > c_s) : (in_seg.end_y < c_s);
    in_a  = KEEP_BELOW ? (in_seg.start_y < c_s) : (in_seg.start_y > c_s);
    in_b  = KEEP_BELOW ? (in_seg.end_y < c_s) : (in_seg.end_y > c_s);
    dn  = {c_s[CoordW-1], c_s} - {in_seg.start_y[CoordW-1], in_seg.start_y};
    dx  = {in_seg.end_x[CoordW-1], in_seg.end_x} - {in_seg.start_x[CoordW-1], in_seg.start_x};
    dy  = {in_seg.end_y[CoordW-1], in_seg.end_y} - {in_seg.start_y[CoordW-1], in_seg.start_y};
    mdn = dn[MagW-1] ? MagW'(-dn) : MagW'(dn);
    mdx = dx[MagW-1] ? MagW'(-dx) : MagW'(dx);
    mdy = dy[MagW-1] ? MagW'(-dy) : MagW'(dy);
    prod = mdn * mdx;

    head_next           = '0;
    head_next.seg       = in_seg;
    head_next.c         = bound;
    head_next.neg       = dn[MagW-1] ^ dx[MagW-1] ^ dy[MagW-1];
    head_next.den       = mdy;
    // quotient stays below 2^33, so the upper half is already below den
    head_next.rem       = {1'b0, prod[ProdW-1:MagW]};
    head_next.low       = prod[MagW-1:0];
    if (!clip_enable) begin
      head_next.valid = in_valid;
    end else begin
      head_next.rep_start = out_a && in_b;
      head_next.rep_end   = in_a && out_b;
      head_next.valid     = in_valid && !out_a && !out_b
                            || in_valid && out_a && in_b
                            || in_valid && in_a && out_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0] <= head_next;
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    shbc_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  shbc_cell_t tail;
  logic signed [CoordW+2:0] xa_w, r_w;
  logic signed [CoordW-1:0] x_sat;
  shbc_seg_t  seg_next;

  always_comb begin
    tail = chain[DivSteps];
    xa_w = (CoordW+3)'(tail.seg.start_x);
    r_w  = tail.neg ? xa_w - signed'({2'b00, tail.quo})
                    : xa_w + signed'({2'b00, tail.quo});
    if (r_w > (CoordW+3)'(32'sh7fffffff)) begin
      x_sat = 32'sh7fffffff;
    end else if (r_w < -(CoordW+3)'(33'sh080000000)) begin
      x_sat = 32'sh80000000;
    end else begin
      x_sat = r_w[CoordW-1:0];
    end
    seg_next = tail.seg;
    if (tail.rep_start) begin
      seg_next.start_x = x_sat;
      seg_next.start_y = signed'(tail.c);
    end
    if (tail.rep_end) begin
      seg_next.end_x = x_sat;
      seg_next.end_y = signed'(tail.c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tail.valid;
      out_seg   <= seg_next;
    end
  end

endmodule

>>> rtl/core/segment_horizontal_band_clip_top.sv
// Horizontal band clipper for 2D segments: upper clip stage, then lower.
// Per stage: a setup/multiply register, 33 divider cells, an update register.
// Throughput one segment per cycle; the 33-cell restoring divider chain in
// each stage takes a new dividend every cycle. Any output stall halts the row.
// Reset (rst, synchronous, active high) clears all valid bits and the
// registers clip_enable, y_lower and y_upper to zero.
module segment_horizontal_band_clip_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // start_x, start_y, end_x, end_y
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // out_start_x, out_start_y, out_end_x, out_end_y
);
  import shbc_pkg::*;

  logic              clip_enable;
  logic [CoordW-1:0] y_lower;
  logic [CoordW-1:0] y_upper;

  // hold configuration; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_enable <= 1'b0;
      y_lower     <= '0;
      y_upper     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegClipEnable: clip_enable <= cfg_data[0];
        RegYLower:     y_lower     <= cfg_data;
        RegYUpper:     y_upper     <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the whole row unless a finished result is stalled
  logic en;
  assign en       = !(m_tvalid && !m_tready);
  assign s_tready = en;

  logic      mid_valid;
  shbc_seg_t mid_seg;
  shbc_seg_t out_seg;

  // clip against y_upper first, keeping what lies at or below it
  shbc_stage #(.KEEP_BELOW(1'b1)) u_upper (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .clip_enable (clip_enable),
    .bound       (y_upper),
    .in_valid    (s_tvalid),
    .in_seg      (shbc_seg_t'(s_tdata)),
    .out_valid   (mid_valid),
    .out_seg     (mid_seg)
  );

  // then against y_lower, keeping what lies at or above it
  shbc_stage #(.KEEP_BELOW(1'b0)) u_lower (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .clip_enable (clip_enable),
    .bound       (y_lower),
    .in_valid    (mid_valid),
    .in_seg      (mid_seg),
    .out_valid   (m_tvalid),
    .out_seg     (out_seg)
  );

  assign m_tdata = out_seg;

  a_ready_follows_stall: assert property (@(posedge clk) disable iff (rst)
    s_tready == !(m_tvalid && !m_tready))
    else $error("input ready does not follow the output stall");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_stall_holds_middle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(mid_valid) && $stable(mid_seg))
    else $error("inner stage moved during a stall");

endmodule
